// ===== rtl/core/tile_viewport_blit_generator_assert.svh =====
// assertion macros for the tile viewport blit generator
// expects clk and arst_n in the scope where a macro is used
`ifndef TILE_VIEWPORT_BLIT_GENERATOR_ASSERT_SVH
`define TILE_VIEWPORT_BLIT_GENERATOR_ASSERT_SVH

// condition must never hold outside reset
`define TVB_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TVB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define TVB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tvb_pkg.sv =====
// shared constants, types and state codes of the tile viewport blit generator
// no dependencies
`default_nettype none

package tvb_pkg;

	localparam int MAP_TILES   = 4096;
	localparam int VIEW_TILES  = 8;
	localparam int ANIM_DRAWS  = 8;
	localparam int ANIM_FRAMES = 3;

	localparam int GID_W  = 16;
	localparam int PIX_W  = 15;
	localparam int SIZE_W = 13;
	localparam int MW_W   = 13;
	localparam int TP_W   = 7;
	localparam int SCR_W  = 11;
	localparam int SHX_W  = 8;
	localparam int SHY_W  = 23;
	localparam int MI_W   = 12;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_PIXELS = 1'd1;

	localparam logic [MW_W-1:0] MW_RESET = 13'd1;
	localparam logic [TP_W-1:0] TP_RESET = 7'd16;

	localparam int ADDR_W     = $clog2(MAP_TILES);
	localparam int COUNT_W    = $clog2(MAP_TILES + 1);
	localparam int VIEW_W     = $clog2(VIEW_TILES + 1);
	localparam int DRAW_CNT_W = $clog2(ANIM_DRAWS + 1);
	localparam int FRAME_W    = (ANIM_FRAMES > 0) ? $clog2(ANIM_FRAMES + 1) : 1;

	// tile row or column: pixel coordinate over tile size plus walk offset
	localparam int ROW_W = PIX_W + 1;
	// row-major index before range check
	localparam int IDX_W = PIX_W + MW_W + 2;

	localparam int DIV_LANES = 4;
	localparam int DIV_CNT_W = $clog2(PIX_W);
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_W = 2;
	localparam int LANE_H = 3;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_BASE,
		BK_ADDR,
		BK_READ,
		BK_EMIT,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic [GID_W-1:0]  gid;
		logic              animated;
		logic              dirty;
		logic [PIX_W-1:0]  vx;
		logic [PIX_W-1:0]  vy;
		logic [SIZE_W-1:0] vw;
		logic [SIZE_W-1:0] vh;
		logic              force_draw;
	} cmd_t;

	typedef struct packed {
		logic                    draw_valid;
		logic signed [SCR_W-1:0] screen_x;
		logic signed [SCR_W-1:0] screen_y;
		logic [SHX_W-1:0]        sheet_x;
		logic signed [SHY_W-1:0] sheet_y;
		logic [MI_W-1:0]         map_index;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic [MW_W-1:0] map_width;
		logic [TP_W-1:0] tile_pixels;
	} cfg_t;

	typedef logic [DIV_LANES-1:0][PIX_W-1:0] div_vec_t;

endpackage

`default_nettype wire

// ===== rtl/core/tvb_front.sv =====
// front end: accepts items, decodes the request type, holds them in a short command queue
// depends on tvb_pkg
`default_nettype none

module tvb_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       req_type,
	input  logic [tvb_pkg::GID_W-1:0]  tile_gid,
	input  logic                       tile_animated,
	input  logic                       tile_dirty,
	input  logic [tvb_pkg::PIX_W-1:0]  view_x,
	input  logic [tvb_pkg::PIX_W-1:0]  view_y,
	input  logic [tvb_pkg::SIZE_W-1:0] view_w,
	input  logic [tvb_pkg::SIZE_W-1:0] view_h,
	input  logic                       force_req,
	output tvb_pkg::cmd_t              cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_pop
);

	tvb_pkg::cmd_t in_cmd;
	tvb_pkg::cmd_t queue_q [tvb_pkg::CMDQ_DEPTH];
	logic [tvb_pkg::CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tvb_pkg::CMDQ_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	always_comb begin
		in_cmd.op         = req_type ? tvb_pkg::OP_DRAW : tvb_pkg::OP_LOAD;
		in_cmd.gid        = tile_gid;
		in_cmd.animated   = tile_animated;
		in_cmd.dirty      = tile_dirty;
		in_cmd.vx         = view_x;
		in_cmd.vy         = view_y;
		in_cmd.vw         = view_w;
		in_cmd.vh         = view_h;
		in_cmd.force_draw = force_req;
	end

	assign full      = (cnt_q == tvb_pkg::CMDQ_CNT_W'(tvb_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == tvb_pkg::CMDQ_PTR_W'(tvb_pkg::CMDQ_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + tvb_pkg::CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				if (rd_ptr_q == tvb_pkg::CMDQ_PTR_W'(tvb_pkg::CMDQ_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + tvb_pkg::CMDQ_PTR_W'(1);
			end
			if (do_push && !do_pop)
				cnt_q <= cnt_q + tvb_pkg::CMDQ_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - tvb_pkg::CMDQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			queue_q[wr_ptr_q] <= in_cmd;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tvb_div.sv =====
// four-lane restoring divider by the tile size, one quotient bit per cycle
// depends on tvb_pkg
`default_nettype none

module tvb_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tvb_pkg::TP_W-1:0] divisor,
	input  tvb_pkg::div_vec_t        dividend,
	output logic                     done,
	output tvb_pkg::div_vec_t        quotient
);

	typedef logic [tvb_pkg::DIV_LANES-1:0][tvb_pkg::TP_W-1:0] rem_vec_t;

	logic busy_q, done_q;
	logic [tvb_pkg::DIV_CNT_W-1:0] step_q;
	logic [tvb_pkg::TP_W-1:0] dvs_q;
	tvb_pkg::div_vec_t quo_q, quo_d;
	rem_vec_t rem_q, rem_d;

	always_comb begin
		logic [tvb_pkg::TP_W:0] trial;
		trial = '0;
		for (int i = 0; i < tvb_pkg::DIV_LANES; i++) begin
			// shifted remainder can reach twice the divisor less one, so it needs one bit more
			trial = {rem_q[i], quo_q[i][tvb_pkg::PIX_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_d[i] = tvb_pkg::TP_W'(trial - {1'b0, dvs_q});
				quo_d[i] = {quo_q[i][tvb_pkg::PIX_W-2:0], 1'b1};
			end else begin
				rem_d[i] = trial[tvb_pkg::TP_W-1:0];
				quo_d[i] = {quo_q[i][tvb_pkg::PIX_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + tvb_pkg::DIV_CNT_W'(1);
				if (step_q == tvb_pkg::DIV_CNT_W'(tvb_pkg::PIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tvb_back.sv =====
// back end: tile store, animation counter, viewport division and the tile walk
// depends on tvb_pkg and tvb_div
`default_nettype none

module tvb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tvb_pkg::cfg_t cfg,
	input  tvb_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	output logic          res_push,
	output tvb_pkg::res_t res,
	input  logic          res_full
);

	typedef struct packed {
		logic [tvb_pkg::GID_W-1:0] gid;
		logic                      dirty;
		logic                      animated;
	} tile_t;

	tile_t mem [tvb_pkg::MAP_TILES];
	tile_t rd_q;

	tvb_pkg::back_state_t state_q, state_d;

	logic [tvb_pkg::COUNT_W-1:0]    loaded_count_q;
	logic [tvb_pkg::DRAW_CNT_W-1:0] draw_cnt_q, draw_cnt_inc;
	logic [tvb_pkg::FRAME_W-1:0]    frame_q;
	logic [tvb_pkg::VIEW_W-1:0]     r_q, c_q;
	logic                           pend_valid_q;

	logic [tvb_pkg::TP_W-1:0]   ts_q, ts_eff;
	logic [tvb_pkg::PIX_W-1:0]  vx_q, vy_q, sx_q, sy_q;
	logic                       force_q;
	logic [tvb_pkg::VIEW_W-1:0] nw_q, nh_q;
	logic [tvb_pkg::IDX_W-1:0]  row_base_q;
	logic [tvb_pkg::ROW_W-1:0]  col_s1, row_s1;
	logic [tvb_pkg::MI_W-1:0]   idx_s1;
	logic [tvb_pkg::SCR_W-1:0]  prod_x_s2, prod_y_s2;
	logic [tvb_pkg::SHX_W-1:0]  prod_shx_s2;
	logic [tvb_pkg::SHY_W-1:0]  prod_shy_s2;
	tvb_pkg::res_t              pend_q;

	logic div_start, div_done;
	tvb_pkg::div_vec_t div_in, div_quo;

	logic [tvb_pkg::ROW_W-1:0]             col, row;
	logic [tvb_pkg::IDX_W-1:0]             idx;
	logic [tvb_pkg::PIX_W+tvb_pkg::MW_W-1:0] base_prod;
	logic [tvb_pkg::ROW_W+tvb_pkg::TP_W-1:0] px, py;
	logic [tvb_pkg::FRAME_W+tvb_pkg::TP_W-1:0] pf;
	logic signed [tvb_pkg::GID_W:0]          gm1;
	logic signed [tvb_pkg::GID_W+tvb_pkg::TP_W:0] pg;

	logic in_range, last_c, last_r, walk_end, tile_wanted;
	logic mem_we, draw_start, step, take;
	tvb_pkg::res_t blit, fin;

	assign ts_eff = (cfg.tile_pixels == '0) ? tvb_pkg::TP_W'(1) : cfg.tile_pixels;

	always_comb begin
		div_in = '0;
		div_in[tvb_pkg::LANE_X] = cmd.vx;
		div_in[tvb_pkg::LANE_Y] = cmd.vy;
		div_in[tvb_pkg::LANE_W] = tvb_pkg::PIX_W'(cmd.vw);
		div_in[tvb_pkg::LANE_H] = tvb_pkg::PIX_W'(cmd.vh);
	end

	tvb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (ts_eff),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_quo)
	);

	// walk position and row-major index
	assign col       = tvb_pkg::ROW_W'(sx_q) + tvb_pkg::ROW_W'(c_q);
	assign row       = tvb_pkg::ROW_W'(sy_q) + tvb_pkg::ROW_W'(r_q);
	assign idx       = row_base_q + tvb_pkg::IDX_W'(col);
	assign base_prod = sy_q * cfg.map_width;
	assign in_range  = (idx < tvb_pkg::IDX_W'(loaded_count_q))
		&& (idx < tvb_pkg::IDX_W'(tvb_pkg::MAP_TILES));
	assign last_c    = (c_q == nw_q - tvb_pkg::VIEW_W'(1));
	assign last_r    = (r_q == nh_q - tvb_pkg::VIEW_W'(1));
	assign walk_end  = last_c && last_r;
	assign tile_wanted = force_q || rd_q.animated || rd_q.dirty;

	// blit coordinate products
	assign px  = col_s1 * ts_q;
	assign py  = row_s1 * ts_q;
	assign pf  = frame_q * ts_q;
	assign gm1 = $signed({1'b0, rd_q.gid}) - $signed((tvb_pkg::GID_W+1)'(1));
	assign pg  = gm1 * $signed({1'b0, ts_q});

	assign draw_cnt_inc = draw_cnt_q + tvb_pkg::DRAW_CNT_W'(1);

	always_comb begin
		blit.draw_valid = 1'b1;
		blit.screen_x   = $signed(prod_x_s2 - vx_q[tvb_pkg::SCR_W-1:0]);
		blit.screen_y   = $signed(prod_y_s2 - vy_q[tvb_pkg::SCR_W-1:0]);
		blit.sheet_x    = prod_shx_s2;
		blit.sheet_y    = $signed(prod_shy_s2);
		blit.map_index  = idx_s1;
		blit.last       = 1'b0;
		fin = pend_q;
		fin.last = 1'b1;
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		mem_we     = 1'b0;
		draw_start = 1'b0;
		div_start  = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		step       = 1'b0;
		take       = 1'b0;
		case (state_q)
			tvb_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == tvb_pkg::OP_DRAW) begin
						draw_start = 1'b1;
						div_start  = 1'b1;
						state_d    = tvb_pkg::BK_DIV;
					end else begin
						mem_we = (loaded_count_q < tvb_pkg::COUNT_W'(tvb_pkg::MAP_TILES));
					end
				end
			end
			tvb_pkg::BK_DIV: begin
				if (div_done)
					state_d = tvb_pkg::BK_BASE;
			end
			tvb_pkg::BK_BASE: begin
				if (nw_q == '0 || nh_q == '0)
					state_d = tvb_pkg::BK_FLUSH;
				else
					state_d = tvb_pkg::BK_ADDR;
			end
			tvb_pkg::BK_ADDR: begin
				if (in_range) begin
					state_d = tvb_pkg::BK_READ;
				end else begin
					step    = 1'b1;
					state_d = walk_end ? tvb_pkg::BK_FLUSH : tvb_pkg::BK_ADDR;
				end
			end
			tvb_pkg::BK_READ: begin
				if (tile_wanted) begin
					state_d = tvb_pkg::BK_EMIT;
				end else begin
					step    = 1'b1;
					state_d = walk_end ? tvb_pkg::BK_FLUSH : tvb_pkg::BK_ADDR;
				end
			end
			tvb_pkg::BK_EMIT: begin
				// the held blit goes out once a newer one proves it is not last
				if (!pend_valid_q || !res_full) begin
					res_push = pend_valid_q;
					res      = pend_q;
					take     = 1'b1;
					step     = 1'b1;
					state_d  = walk_end ? tvb_pkg::BK_FLUSH : tvb_pkg::BK_ADDR;
				end
			end
			tvb_pkg::BK_FLUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (pend_valid_q) begin
						res = fin;
					end else begin
						res      = '0;
						res.last = 1'b1;
					end
					state_d = tvb_pkg::BK_IDLE;
				end
			end
			default: state_d = tvb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tvb_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q <= '0;
			draw_cnt_q     <= '0;
			frame_q        <= '0;
			r_q            <= '0;
			c_q            <= '0;
			pend_valid_q   <= 1'b0;
		end else begin
			if (mem_we)
				loaded_count_q <= loaded_count_q + tvb_pkg::COUNT_W'(1);
			if (draw_start) begin
				pend_valid_q <= 1'b0;
				if (draw_cnt_inc >= tvb_pkg::DRAW_CNT_W'(tvb_pkg::ANIM_DRAWS)) begin
					draw_cnt_q <= '0;
					if (frame_q >= tvb_pkg::FRAME_W'(tvb_pkg::ANIM_FRAMES))
						frame_q <= '0;
					else
						frame_q <= frame_q + tvb_pkg::FRAME_W'(1);
				end else begin
					draw_cnt_q <= draw_cnt_inc;
				end
			end else if (take) begin
				pend_valid_q <= 1'b1;
			end
			if (state_q == tvb_pkg::BK_BASE) begin
				r_q <= '0;
				c_q <= '0;
			end else if (step) begin
				if (last_c) begin
					c_q <= '0;
					r_q <= r_q + tvb_pkg::VIEW_W'(1);
				end else begin
					c_q <= c_q + tvb_pkg::VIEW_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_start) begin
			vx_q    <= cmd.vx;
			vy_q    <= cmd.vy;
			force_q <= cmd.force_draw;
			ts_q    <= ts_eff;
		end
		if (state_q == tvb_pkg::BK_DIV && div_done) begin
			sx_q <= div_quo[tvb_pkg::LANE_X];
			sy_q <= div_quo[tvb_pkg::LANE_Y];
			if (div_quo[tvb_pkg::LANE_W] > tvb_pkg::PIX_W'(tvb_pkg::VIEW_TILES))
				nw_q <= tvb_pkg::VIEW_W'(tvb_pkg::VIEW_TILES);
			else
				nw_q <= div_quo[tvb_pkg::LANE_W][tvb_pkg::VIEW_W-1:0];
			if (div_quo[tvb_pkg::LANE_H] > tvb_pkg::PIX_W'(tvb_pkg::VIEW_TILES))
				nh_q <= tvb_pkg::VIEW_W'(tvb_pkg::VIEW_TILES);
			else
				nh_q <= div_quo[tvb_pkg::LANE_H][tvb_pkg::VIEW_W-1:0];
		end
		if (state_q == tvb_pkg::BK_BASE)
			row_base_q <= tvb_pkg::IDX_W'(base_prod);
		else if (step && last_c)
			row_base_q <= row_base_q + tvb_pkg::IDX_W'(cfg.map_width);
		if (state_q == tvb_pkg::BK_ADDR) begin
			col_s1 <= col;
			row_s1 <= row;
			idx_s1 <= idx[tvb_pkg::MI_W-1:0];
		end
		if (state_q == tvb_pkg::BK_READ) begin
			prod_x_s2   <= px[tvb_pkg::SCR_W-1:0];
			prod_y_s2   <= py[tvb_pkg::SCR_W-1:0];
			prod_shx_s2 <= pf[tvb_pkg::SHX_W-1:0];
			prod_shy_s2 <= pg[tvb_pkg::SHY_W-1:0];
		end
		if (take)
			pend_q <= blit;
	end

	// tile store: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[loaded_count_q[tvb_pkg::ADDR_W-1:0]] <= '{cmd.gid, cmd.dirty, cmd.animated};
		if (state_q == tvb_pkg::BK_ADDR)
			rd_q <= mem[idx[tvb_pkg::ADDR_W-1:0]];
	end

endmodule

`default_nettype wire

// ===== rtl/core/tvb_outq.sv =====
// result queue between the tile walk and the result ports
// depends on tvb_pkg
`default_nettype none

module tvb_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tvb_pkg::res_t din,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output tvb_pkg::res_t dout
);

	tvb_pkg::res_t queue_q [tvb_pkg::OUTQ_DEPTH];
	logic [tvb_pkg::OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tvb_pkg::OUTQ_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == tvb_pkg::OUTQ_CNT_W'(tvb_pkg::OUTQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == tvb_pkg::OUTQ_PTR_W'(tvb_pkg::OUTQ_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + tvb_pkg::OUTQ_PTR_W'(1);
			end
			if (do_pop) begin
				if (rd_ptr_q == tvb_pkg::OUTQ_PTR_W'(tvb_pkg::OUTQ_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + tvb_pkg::OUTQ_PTR_W'(1);
			end
			if (do_push && !do_pop)
				cnt_q <= cnt_q + tvb_pkg::OUTQ_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - tvb_pkg::OUTQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			queue_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tile_viewport_blit_generator.sv =====
// top level of the tile viewport blit generator: configuration registers,
// front end, back end and result queue
// depends on tvb_pkg, tvb_front, tvb_back, tvb_outq and the assertion header
//
// Load items append one tile (gid, dirty, animated) to a 4096-entry tile store and
// give no result; loads past a full store are dropped. A draw item steps the
// animation, divides the pixel viewport by the tile size and walks up to 8 by 8
// visible tiles row by row, giving one blit per loaded tile that is animated, dirty
// or forced, with last set on the final one, or a single empty result with last set
// when nothing is drawn. Items enter a two-deep command queue; results leave through
// a four-deep queue. A load is written to the store straight from the idle state. A
// draw runs the tile-size divider, one quotient bit per cycle, then a base step, and
// visits each visible tile in an address step, plus a read step of the single store
// read port when it is loaded and an emit step, which waits while the result queue
// is full, when it is drawn; a flush step ends it. The store is not cleared after
// reset: only loaded entries are ever read. Write the configuration only while idle.
`default_nettype none
`include "tile_viewport_blit_generator_assert.svh"

module tile_viewport_blit_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           req_type,
	input  logic [tvb_pkg::GID_W-1:0]      tile_gid,
	input  logic                           tile_animated,
	input  logic                           tile_dirty,
	input  logic [tvb_pkg::PIX_W-1:0]      view_x,
	input  logic [tvb_pkg::PIX_W-1:0]      view_y,
	input  logic [tvb_pkg::SIZE_W-1:0]     view_w,
	input  logic [tvb_pkg::SIZE_W-1:0]     view_h,
	input  logic                           force_req,
	output logic                           empty,
	input  logic                           pop,
	output logic                           draw_valid,
	output logic signed [tvb_pkg::SCR_W-1:0] screen_x,
	output logic signed [tvb_pkg::SCR_W-1:0] screen_y,
	output logic [tvb_pkg::SHX_W-1:0]      sheet_x,
	output logic signed [tvb_pkg::SHY_W-1:0] sheet_y,
	output logic [tvb_pkg::MI_W-1:0]       map_index,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [tvb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvb_pkg::CFG_DATA_W-1:0] cfg_data
);

	tvb_pkg::cfg_t cfg_q;
	tvb_pkg::cmd_t cmd;
	tvb_pkg::res_t res, head;
	logic cmd_valid, cmd_pop, res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width   <= tvb_pkg::MW_RESET;
			cfg_q.tile_pixels <= tvb_pkg::TP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tvb_pkg::CFG_MAP_WIDTH:   cfg_q.map_width   <= cfg_data[tvb_pkg::MW_W-1:0];
				tvb_pkg::CFG_TILE_PIXELS: cfg_q.tile_pixels <= cfg_data[tvb_pkg::TP_W-1:0];
				default: ;
			endcase
		end
	end

	tvb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.tile_gid      (tile_gid),
		.tile_animated (tile_animated),
		.tile_dirty    (tile_dirty),
		.view_x        (view_x),
		.view_y        (view_y),
		.view_w        (view_w),
		.view_h        (view_h),
		.force_req     (force_req),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop)
	);

	tvb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	tvb_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (head)
	);

	assign draw_valid = head.draw_valid;
	assign screen_x   = head.screen_x;
	assign screen_y   = head.screen_y;
	assign sheet_x    = head.sheet_x;
	assign sheet_y    = head.sheet_y;
	assign map_index  = head.map_index;
	assign last       = head.last;

	`TVB_ASSERT_NEVER(a_push_into_full, res_push && res_full, "result pushed into a full queue")
	`TVB_ASSERT_NEVER(a_pop_empty_cmd, cmd_pop && !cmd_valid, "command taken from an empty queue")
	`TVB_ASSERT_IMPL(a_marker_last, res_push && !res.draw_valid, res.last, "empty result without last")
	`TVB_ASSERT_NEXT(a_tp_write, cfg_we && cfg_index == tvb_pkg::CFG_TILE_PIXELS, cfg_q.tile_pixels == $past(cfg_data[tvb_pkg::TP_W-1:0]), "tile size write lost")

endmodule

`default_nettype wire
